// ===== rtl/ftbs_pkg.sv =====
// ftbs_pkg: shared types and defaults for the frame time bracket search
// no dependencies; imported by ftbs_seq and frame_time_bracket_search
`timescale 1ns / 1ps

package ftbs_pkg;

  localparam int MAX_FRAMES_DEF    = 256;
  localparam int TIME_BITS_DEF     = 32;
  localparam int FRACTION_BITS_DEF = 16;

  // command codes on the cmd input
  localparam logic CMD_WRITE = 1'b0;
  localparam logic CMD_QUERY = 1'b1;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_FIRST,
    ST_LAST,
    ST_PROBE,
    ST_COMPARE,
    ST_READ_LOWER,
    ST_READ_UPPER,
    ST_SPAN,
    ST_NEAR_DIFF,
    ST_NEAR_PICK,
    ST_DIV_CHECK,
    ST_DIVIDE
  } state_t;

endpackage

// ===== rtl/frame_time_bracket_search.sv =====
// frame_time_bracket_search: top level, frame count register and unit wiring
// depends on ftbs_pkg, ftbs_table, ftbs_alu, ftbs_seq
`timescale 1ns / 1ps

// Holds up to MAX_FRAMES timestamps (unsigned Q16.16) and answers bracket
// queries. A word is taken when start is high and busy is low; its result
// appears for exactly one cycle with done high and must be captured then,
// since the block cannot be stalled. A table write (cmd 0) acknowledges in the
// cycle after it is taken. A query with no frames, or one that clamps to
// the first or last frame, ends without a search; any other query walks a
// binary search and a restoring division through one table read port and
// one shared subtractor; the division is skipped when the upper bracketing
// time does not exceed the lower or the query is not below the upper. The
// table has no reset: write every entry below frame_count before querying.
// frame_count is to be written only while busy is low; the block does not
// enforce this. It saturates at MAX_FRAMES and resets to zero.
module frame_time_bracket_search
  import ftbs_pkg::*;
#(
  parameter int MAX_FRAMES    = MAX_FRAMES_DEF,
  parameter int TIME_BITS     = TIME_BITS_DEF,
  parameter int FRACTION_BITS = FRACTION_BITS_DEF,
  localparam int IDX_W = $clog2(MAX_FRAMES),
  localparam int CNT_W = $clog2(MAX_FRAMES + 1)
) (
  input  logic                     clk,
  input  logic                     rst,
  input  logic                     cfg_write,
  input  logic [CNT_W-1:0]         cfg_data,
  input  logic                     start,
  output logic                     busy,
  input  logic                     cmd,
  input  logic [IDX_W-1:0]         entry_index,
  input  logic [TIME_BITS-1:0]     time_value,
  output logic                     done,
  output logic                     is_query,
  output logic                     no_frames,
  output logic [IDX_W-1:0]         lower_frame,
  output logic [IDX_W-1:0]         upper_frame,
  output logic [IDX_W-1:0]         nearest_frame,
  output logic [FRACTION_BITS-1:0] blend_fraction
);

  localparam int ALU_W = TIME_BITS + 1;

  logic [CNT_W-1:0]     frame_count;
  logic                 wr_en;
  logic [IDX_W-1:0]     wr_addr;
  logic [TIME_BITS-1:0] wr_data;
  logic [IDX_W-1:0]     rd_addr;
  logic [TIME_BITS-1:0] rd_data;
  logic [ALU_W-1:0]     alu_a;
  logic [ALU_W-1:0]     alu_b;
  logic [ALU_W-1:0]     alu_diff;
  logic                 alu_borrow;

  always_ff @(posedge clk) begin
    if (rst) begin
      frame_count <= '0;
    end else if (cfg_write) begin
      frame_count <= (cfg_data > CNT_W'(MAX_FRAMES)) ? CNT_W'(MAX_FRAMES) : cfg_data;
    end
  end

  ftbs_table #(
    .DEPTH (MAX_FRAMES),
    .AW    (IDX_W),
    .DW    (TIME_BITS)
  ) u_table (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (wr_addr),
    .wr_data (wr_data),
    .rd_addr (rd_addr),
    .rd_data (rd_data)
  );

  ftbs_alu #(
    .W (ALU_W)
  ) u_alu (
    .a      (alu_a),
    .b      (alu_b),
    .diff   (alu_diff),
    .borrow (alu_borrow)
  );

  ftbs_seq #(
    .MAX_FRAMES    (MAX_FRAMES),
    .TIME_BITS     (TIME_BITS),
    .FRACTION_BITS (FRACTION_BITS)
  ) u_seq (
    .clk            (clk),
    .rst            (rst),
    .start          (start),
    .cmd            (cmd),
    .entry_index    (entry_index),
    .time_value     (time_value),
    .n              (frame_count),
    .busy           (busy),
    .done           (done),
    .is_query       (is_query),
    .no_frames      (no_frames),
    .lower_frame    (lower_frame),
    .upper_frame    (upper_frame),
    .nearest_frame  (nearest_frame),
    .blend_fraction (blend_fraction),
    .wr_en          (wr_en),
    .wr_addr        (wr_addr),
    .wr_data        (wr_data),
    .rd_addr        (rd_addr),
    .rd_data        (rd_data),
    .alu_a          (alu_a),
    .alu_b          (alu_b),
    .alu_diff       (alu_diff),
    .alu_borrow     (alu_borrow)
  );

endmodule

// ===== rtl/ftbs_table.sv =====
// ftbs_table: timestamp memory, one write port and one registered read port
// no package dependencies
`timescale 1ns / 1ps

module ftbs_table #(
  parameter int DEPTH = 256,
  parameter int AW    = 8,
  parameter int DW    = 32
) (
  input  logic          clk,
  input  logic          wr_en,
  input  logic [AW-1:0] wr_addr,
  input  logic [DW-1:0] wr_data,
  input  logic [AW-1:0] rd_addr,
  output logic [DW-1:0] rd_data
);

  logic [DW-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    rd_data <= mem[rd_addr];
  end

endmodule

// ===== rtl/ftbs_alu.sv =====
// ftbs_alu: the one shared subtractor; every compare and division step uses it
// no package dependencies
`timescale 1ns / 1ps

module ftbs_alu #(
  parameter int W = 33
) (
  input  logic [W-1:0] a,
  input  logic [W-1:0] b,
  output logic [W-1:0] diff,
  output logic         borrow
);

  // borrow set means a < b
  assign {borrow, diff} = {1'b0, a} - {1'b0, b};

endmodule

// ===== rtl/ftbs_seq.sv =====
// ftbs_seq: sequencer and datapath registers for search, nearest pick and division
// depends on ftbs_pkg; drives ftbs_table and ftbs_alu from the top level
`timescale 1ns / 1ps

module ftbs_seq
  import ftbs_pkg::*;
#(
  parameter int MAX_FRAMES    = MAX_FRAMES_DEF,
  parameter int TIME_BITS     = TIME_BITS_DEF,
  parameter int FRACTION_BITS = FRACTION_BITS_DEF,
  localparam int IDX_W = $clog2(MAX_FRAMES),
  localparam int CNT_W = $clog2(MAX_FRAMES + 1),
  localparam int ALU_W = TIME_BITS + 1
) (
  input  logic                     clk,
  input  logic                     rst,
  input  logic                     start,
  input  logic                     cmd,
  input  logic [IDX_W-1:0]         entry_index,
  input  logic [TIME_BITS-1:0]     time_value,
  input  logic [CNT_W-1:0]         n,
  output logic                     busy,
  output logic                     done,
  output logic                     is_query,
  output logic                     no_frames,
  output logic [IDX_W-1:0]         lower_frame,
  output logic [IDX_W-1:0]         upper_frame,
  output logic [IDX_W-1:0]         nearest_frame,
  output logic [FRACTION_BITS-1:0] blend_fraction,
  // table ports
  output logic                     wr_en,
  output logic [IDX_W-1:0]         wr_addr,
  output logic [TIME_BITS-1:0]     wr_data,
  output logic [IDX_W-1:0]         rd_addr,
  input  logic [TIME_BITS-1:0]     rd_data,
  // shared subtractor ports
  output logic [ALU_W-1:0]         alu_a,
  output logic [ALU_W-1:0]         alu_b,
  input  logic [ALU_W-1:0]         alu_diff,
  input  logic                     alu_borrow
);

  localparam int CW = $clog2(FRACTION_BITS);

  state_t state, state_next;

  logic [TIME_BITS-1:0]     t;
  logic [TIME_BITS-1:0]     ta;
  logic [TIME_BITS-1:0]     tb;
  logic [TIME_BITS-1:0]     num;
  logic [TIME_BITS-1:0]     den;
  logic [TIME_BITS-1:0]     tbmt;
  logic [TIME_BITS-1:0]     rem;
  logic                     den_zero;
  logic                     tb_ge_t;
  logic [CNT_W-1:0]         lo;
  logic [CNT_W-1:0]         len;
  logic [CNT_W-1:0]         probe;
  logic [IDX_W-1:0]         lower;
  logic [IDX_W-1:0]         upper;
  logic [IDX_W-1:0]         nearest;
  logic [FRACTION_BITS-1:0] frac;
  logic [CW-1:0]            cnt;

  logic [CNT_W-1:0] n_last;
  logic [CNT_W-1:0] probe_c;
  logic [CNT_W-1:0] upper_c;
  logic [CNT_W-1:0] lower_c;
  logic             one_frame;
  logic             fin;

  assign n_last    = n - 1'b1;
  assign probe_c   = lo + (len >> 1);
  assign one_frame = (n == CNT_W'(1));
  assign lower_c   = upper_c - 1'b1;

  // clamp the search result so that lower and upper stay inside the table
  always_comb begin
    priority if (lo == '0) begin
      upper_c = CNT_W'(1);
    end else if (lo > n_last) begin
      upper_c = n_last;
    end else begin
      upper_c = lo;
    end
  end

  // next state
  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE: begin
        if (start && cmd == CMD_QUERY && n != '0) begin
          state_next = ST_FIRST;
        end
      end
      ST_FIRST: begin
        if (one_frame || !alu_borrow) begin
          state_next = ST_IDLE;
        end else begin
          state_next = ST_LAST;
        end
      end
      ST_LAST: begin
        if (!alu_borrow) begin
          state_next = ST_IDLE;
        end else begin
          state_next = ST_PROBE;
        end
      end
      ST_PROBE: begin
        if (len == '0) begin
          state_next = ST_READ_LOWER;
        end else begin
          state_next = ST_COMPARE;
        end
      end
      ST_COMPARE:    state_next = ST_PROBE;
      ST_READ_LOWER: state_next = ST_READ_UPPER;
      ST_READ_UPPER: state_next = ST_SPAN;
      ST_SPAN:       state_next = ST_NEAR_DIFF;
      ST_NEAR_DIFF:  state_next = ST_NEAR_PICK;
      ST_NEAR_PICK:  state_next = ST_DIV_CHECK;
      ST_DIV_CHECK: begin
        if (den_zero || !alu_borrow) begin
          state_next = ST_IDLE;
        end else begin
          state_next = ST_DIVIDE;
        end
      end
      ST_DIVIDE: begin
        if (cnt == CW'(FRACTION_BITS - 1)) begin
          state_next = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  // control outputs: table addresses and write enable, subtractor operands, finish strobe
  always_comb begin
    rd_addr = '0;
    alu_a   = '0;
    alu_b   = '0;
    fin     = 1'b0;
    wr_en   = 1'b0;
    unique case (state)
      ST_IDLE: begin
        wr_en = start && cmd == CMD_WRITE
                && CNT_W'(entry_index) < CNT_W'(MAX_FRAMES);
        fin   = start && (cmd == CMD_WRITE || n == '0);
      end
      ST_FIRST: begin
        rd_addr = n_last[IDX_W-1:0];
        alu_a   = {1'b0, rd_data};
        alu_b   = {1'b0, t};
        fin     = one_frame || !alu_borrow;
      end
      ST_LAST: begin
        alu_a = {1'b0, t};
        alu_b = {1'b0, rd_data};
        fin   = !alu_borrow;
      end
      ST_PROBE: begin
        rd_addr = probe_c[IDX_W-1:0];
      end
      ST_COMPARE: begin
        alu_a = {1'b0, t};
        alu_b = {1'b0, rd_data};
      end
      ST_READ_LOWER: begin
        rd_addr = lower;
      end
      ST_READ_UPPER: begin
        rd_addr = upper;
        alu_a   = {1'b0, t};
        alu_b   = {1'b0, rd_data};
      end
      ST_SPAN: begin
        alu_a = {1'b0, rd_data};
        alu_b = {1'b0, ta};
      end
      ST_NEAR_DIFF: begin
        alu_a = {1'b0, tb};
        alu_b = {1'b0, t};
      end
      ST_NEAR_PICK: begin
        alu_a = {1'b0, tbmt};
        alu_b = {1'b0, num};
      end
      ST_DIV_CHECK: begin
        alu_a = {1'b0, num};
        alu_b = {1'b0, den};
        fin   = den_zero || !alu_borrow;
      end
      ST_DIVIDE: begin
        alu_a = {rem, 1'b0};
        alu_b = {1'b0, den};
        fin   = (cnt == CW'(FRACTION_BITS - 1));
      end
      default: begin
        rd_addr = '0;
      end
    endcase
  end

  assign wr_addr = entry_index;
  assign wr_data = time_value;
  assign busy    = (state != ST_IDLE);

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
      done  <= 1'b0;
    end else begin
      state <= state_next;
      done  <= fin;
    end
  end

  always_ff @(posedge clk) begin
    unique case (state)
      ST_IDLE: begin
        if (start) begin
          t         <= time_value;
          is_query  <= cmd;
          no_frames <= (cmd == CMD_QUERY) && (n == '0);
          lower     <= '0;
          upper     <= '0;
          nearest   <= '0;
          frac      <= '0;
        end
      end
      ST_FIRST: begin
        lo  <= '0;
        len <= n;
      end
      ST_LAST: begin
        if (!alu_borrow) begin
          lower   <= n_last[IDX_W-1:0];
          upper   <= n_last[IDX_W-1:0];
          nearest <= n_last[IDX_W-1:0];
        end
      end
      ST_PROBE: begin
        probe <= probe_c;
        if (len == '0) begin
          upper <= upper_c[IDX_W-1:0];
          lower <= lower_c[IDX_W-1:0];
        end
      end
      ST_COMPARE: begin
        // borrow means the query lies below the probed entry
        if (alu_borrow) begin
          len <= len >> 1;
        end else begin
          lo  <= probe + 1'b1;
          len <= len - (len >> 1) - 1'b1;
        end
      end
      ST_READ_LOWER: begin
        ta <= ta;
      end
      ST_READ_UPPER: begin
        ta  <= rd_data;
        num <= alu_borrow ? '0 : alu_diff[TIME_BITS-1:0];
      end
      ST_SPAN: begin
        tb       <= rd_data;
        den      <= alu_diff[TIME_BITS-1:0];
        den_zero <= alu_borrow || (alu_diff[TIME_BITS-1:0] == '0);
      end
      ST_NEAR_DIFF: begin
        tb_ge_t <= !alu_borrow;
        tbmt    <= alu_diff[TIME_BITS-1:0];
      end
      ST_NEAR_PICK: begin
        // ties go to the lower frame
        nearest <= (tb_ge_t && !alu_borrow) ? lower : upper;
      end
      ST_DIV_CHECK: begin
        if (den_zero) begin
          frac <= '0;
        end else if (!alu_borrow) begin
          frac <= '1;
        end else begin
          rem  <= num;
          frac <= '0;
          cnt  <= '0;
        end
      end
      ST_DIVIDE: begin
        // restoring step: remainder stays below den, so one subtract per bit
        frac <= {frac[FRACTION_BITS-2:0], !alu_borrow};
        rem  <= alu_borrow ? {rem[TIME_BITS-2:0], 1'b0} : alu_diff[TIME_BITS-1:0];
        cnt  <= cnt + 1'b1;
      end
      default: begin
        t <= t;
      end
    endcase
  end

  assign lower_frame    = lower;
  assign upper_frame    = upper;
  assign nearest_frame  = nearest;
  assign blend_fraction = frac;

endmodule
